// ===== src/cfla_pkg.sv =====
// ---------------------------------------------------------------------------
// cfla_pkg: shared types and codes of the coalescing free-list allocator
// Request and response beats, status and register codes, cell control groups.
// ---------------------------------------------------------------------------
`default_nettype none

package cfla_pkg;

  localparam int SPACE_BYTES  = 262144;
  localparam int THRESH_RESET = 10;
  localparam int GRAIN_UNITS  = 8;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_NO_SPACE   = 3'd1;
  localparam logic [2:0] STAT_NOT_ALLOC  = 3'd2;
  localparam logic [2:0] STAT_TABLE_FULL = 3'd3;
  localparam logic [2:0] STAT_RANGE      = 3'd4;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_BYTES  = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [18:0] alloc_bytes;
    logic [17:0] free_addr;
  } cfla_req_t;

  typedef struct packed {
    logic [17:0] result_addr;
    logic [2:0]  status;
    logic [18:0] free_bytes;
  } cfla_rsp_t;

  typedef struct packed {
    logic clr;
    logic set;
    logic take_next;
    logic take_prev;
  } cfla_free_op_t;

  typedef struct packed {
    logic clr;
    logic set;
    logic take_next;
  } cfla_live_op_t;

endpackage

`default_nettype wire

// ===== src/cfla_free_cell.sv =====
// ---------------------------------------------------------------------------
// cfla_free_cell: one entry of the free extent row
// Loads, clears, or takes the extent of its left or right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module cfla_free_cell #(
  parameter int SW = 14,
  parameter int LW = 15
) (
  input  logic                   clk,
  input  cfla_pkg::cfla_free_op_t op,
  input  logic [SW-1:0]          set_start,
  input  logic [LW-1:0]          set_len,
  input  logic [SW-1:0]          prev_start,
  input  logic [LW-1:0]          prev_len,
  input  logic [SW-1:0]          next_start,
  input  logic [LW-1:0]          next_len,
  output logic [SW-1:0]          start,
  output logic [LW-1:0]          len
);

  always_ff @(posedge clk) begin
    if (op.clr) begin
      start <= '0;
      len   <= '0;
    end else if (op.set) begin
      start <= set_start;
      len   <= set_len;
    end else if (op.take_next) begin
      start <= next_start;
      len   <= next_len;
    end else if (op.take_prev) begin
      start <= prev_start;
      len   <= prev_len;
    end
  end

endmodule

`default_nettype wire

// ===== src/cfla_live_cell.sv =====
// ---------------------------------------------------------------------------
// cfla_live_cell: one slot of the live allocation row
// Holds a valid bit, start and length; loads or takes its right neighbor.
// ---------------------------------------------------------------------------
`default_nettype none

module cfla_live_cell #(
  parameter int SW = 14,
  parameter int LW = 15
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfla_pkg::cfla_live_op_t op,
  input  logic                   set_valid,
  input  logic [SW-1:0]          set_start,
  input  logic [LW-1:0]          set_len,
  input  logic                   next_valid,
  input  logic [SW-1:0]          next_start,
  input  logic [LW-1:0]          next_len,
  output logic                   valid,
  output logic [SW-1:0]          start,
  output logic [LW-1:0]          len
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.clr) begin
      valid <= 1'b0;
    end else if (op.set) begin
      valid <= set_valid;
    end else if (op.take_next) begin
      valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op.set) begin
      start <= set_start;
      len   <= set_len;
    end else if (op.take_next) begin
      start <= next_start;
      len   <= next_len;
    end
  end

endmodule

`default_nettype wire

// ===== src/coalescing_free_list_allocator.sv =====
// ---------------------------------------------------------------------------
// coalescing_free_list_allocator: extent allocator with coalescing free list
// Address-sorted free extents and live allocations held in rows of cells.
// ---------------------------------------------------------------------------
// A request that passes the field checks rotates both cell rows once in full
//   (S_SCAN), then updates the rows in S_APPLY, which registers done.
// A request rejected on its fields alone (size, alignment, range) answers in
//   the next cycle. No new request is taken while busy; the next start can be
//   taken at the edge that ends the strobe cycle.
// Reset: rst is synchronous; after it the tables are rebuilt in S_INIT
//   (busy high), as after each write to the base, size or threshold register.
`default_nettype none

module coalescing_free_list_allocator #(
  parameter int FREE_ENTRIES = 64,
  parameter int LIVE_ENTRIES = 64,
  parameter int ALIGN_BYTES  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cfla_pkg::cfla_req_t request,
  output logic               done,
  output cfla_pkg::cfla_rsp_t response,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_data
);

  import cfla_pkg::*;

  // ALIGN_BYTES is a power of two; units are byte addresses shifted down.
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int GRAIN_BYTES = GRAIN_UNITS * ALIGN_BYTES;
  localparam int SW          = 18 - ALIGN_SHIFT;
  localparam int LW          = SW + 1;
  localparam int IW          = $clog2(FREE_ENTRIES);
  localparam int CW          = $clog2(FREE_ENTRIES + 1);
  localparam int LIW         = $clog2(LIVE_ENTRIES);
  localparam int MAXD        = (FREE_ENTRIES > LIVE_ENTRIES) ? FREE_ENTRIES : LIVE_ENTRIES;
  localparam int TW          = $clog2(MAXD);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0]    state;
  logic [TW-1:0] t;

  // configuration and derived region bounds
  logic [17:0]   region_base;
  logic [18:0]   region_bytes;
  logic [6:0]    ff_thresh;
  logic [LW-1:0] region_lo;
  logic [LW-1:0] region_hi;
  logic [CW-1:0] free_count;
  logic [18:0]   bytes_free;

  // request in flight
  logic          op_free;
  logic          first_fit;
  logic [LW-1:0] units;
  logic [SW-1:0] u_addr;

  // scan results
  logic           slot_found;
  logic           hit;
  logic [LIW-1:0] slot;
  logic           fit_found;
  logic           fit_done;
  logic [IW-1:0]  best;
  logic [SW-1:0]  best_start;
  logic [LW-1:0]  best_len;
  logic [LW-1:0]  waste;
  logic           pos_found;
  logic [CW-1:0]  pos;
  logic           have_prev;
  logic [SW-1:0]  prev_start;
  logic [LW-1:0]  prev_len;
  logic [SW-1:0]  next_start;
  logic [LW-1:0]  next_len;

  // cell rows
  logic [SW-1:0] fs [FREE_ENTRIES];
  logic [LW-1:0] fl [FREE_ENTRIES];
  logic          lv [LIVE_ENTRIES];
  logic [SW-1:0] ls [LIVE_ENTRIES];
  logic [LW-1:0] ll [LIVE_ENTRIES];

  logic rebuild, apply, rot_free, rot_live, f_in, l_in;

  assign rebuild   = (state == S_INIT);
  assign apply     = (state == S_APPLY);
  assign rot_free  = (state == S_SCAN) && (32'(t) < FREE_ENTRIES);
  assign rot_live  = (state == S_SCAN) && (32'(t) < LIVE_ENTRIES);
  assign f_in      = 32'(t) < 32'(free_count);
  assign l_in      = rot_live;
  assign busy      = (state != S_IDLE);
  // a start in the same cycle wins over a register write
  assign cfg_ready = (state == S_IDLE) && !start;

  // ---------------------------------------------------------------- rebuild
  logic [18:0]   base_r, usable_raw, room, usable;
  logic [LW-1:0] lo_units, usable_units;

  always_comb begin
    base_r     = ({1'b0, region_base} + 19'(ALIGN_BYTES - 1)) & ~19'(ALIGN_BYTES - 1);
    usable_raw = region_bytes & ~19'(GRAIN_BYTES - 1);
    room       = 19'(SPACE_BYTES) - base_r;
    if (base_r >= 19'(SPACE_BYTES)) begin
      usable = '0;
    end else if (usable_raw > room) begin
      usable = room & ~19'(GRAIN_BYTES - 1);
    end else begin
      usable = usable_raw;
    end
    lo_units     = LW'(base_r >> ALIGN_SHIFT);
    usable_units = LW'(usable >> ALIGN_SHIFT);
  end

  // ---------------------------------------------------------- field checks
  logic [LW-1:0] req_units, req_addr_units;
  logic          alloc_bad, free_bad;

  always_comb begin
    req_units      = LW'((20'(request.alloc_bytes) + 20'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT);
    req_addr_units = LW'(request.free_addr >> ALIGN_SHIFT);
    alloc_bad      = (request.alloc_bytes == '0) || (request.alloc_bytes > 19'(SPACE_BYTES));
    free_bad       = ((request.free_addr & 18'(ALIGN_BYTES - 1)) != '0) ||
                     (req_addr_units < region_lo) || (req_addr_units >= region_hi);
  end

  // ------------------------------------------------------------ update step
  logic [CW-1:0]  pos_idx;
  logic [LW:0]    prev_end;
  logic           join_prev, join_next;
  logic [18:0]    units_bytes;
  logic [2:0]     a_status;
  logic [17:0]    a_addr;
  logic           f_set, f_shl, f_shr, cnt_dec, cnt_inc;
  logic [IW-1:0]  f_set_idx, f_shift_idx;
  logic [SW-1:0]  f_set_start;
  logic [LW-1:0]  f_set_len;
  logic           l_set, l_set_valid;
  logic [18:0]    bytes_next;

  always_comb begin
    pos_idx     = pos_found ? pos : free_count;
    prev_end    = {1'b0, prev_len} + (LW+1)'(prev_start);
    join_prev   = have_prev && (prev_end == (LW+1)'(u_addr));
    join_next   = pos_found && ((LW+1)'(next_start) == (LW+1)'(u_addr) + (LW+1)'(units));
    units_bytes = 19'(units) << ALIGN_SHIFT;
    a_status    = STAT_OK;
    a_addr      = '0;
    f_set       = 1'b0;
    f_set_idx   = '0;
    f_set_start = '0;
    f_set_len   = '0;
    f_shl       = 1'b0;
    f_shr       = 1'b0;
    f_shift_idx = '0;
    cnt_dec     = 1'b0;
    cnt_inc     = 1'b0;
    l_set       = 1'b0;
    l_set_valid = 1'b0;
    bytes_next  = bytes_free;
    if (op_free == CMD_ALLOC) begin
      if (!slot_found) begin
        a_status = STAT_TABLE_FULL;
      end else if (!fit_found) begin
        a_status = STAT_NO_SPACE;
      end else begin
        a_addr      = 18'(best_start) << ALIGN_SHIFT;
        l_set       = 1'b1;
        l_set_valid = 1'b1;
        bytes_next  = bytes_free - units_bytes;
        if (best_len > units) begin
          // shrink the extent from its low end
          f_set       = 1'b1;
          f_set_idx   = best;
          f_set_start = best_start + SW'(units);
          f_set_len   = best_len - units;
        end else begin
          // exact fit: drop the extent, close the gap
          f_shl       = 1'b1;
          f_shift_idx = best;
          cnt_dec     = 1'b1;
        end
      end
    end else begin
      if (!hit) begin
        a_status = STAT_NOT_ALLOC;
      end else if (!join_prev && !join_next && (32'(free_count) >= FREE_ENTRIES)) begin
        a_status = STAT_TABLE_FULL;
      end else begin
        l_set      = 1'b1;
        bytes_next = bytes_free + units_bytes;
        if (join_prev) begin
          f_set       = 1'b1;
          f_set_idx   = IW'(pos_idx - 1'b1);
          f_set_start = prev_start;
          f_set_len   = prev_len + units + (join_next ? next_len : '0);
          if (join_next) begin
            f_shl       = 1'b1;
            f_shift_idx = IW'(pos_idx);
            cnt_dec     = 1'b1;
          end
        end else if (join_next) begin
          f_set       = 1'b1;
          f_set_idx   = IW'(pos_idx);
          f_set_start = u_addr;
          f_set_len   = next_len + units;
        end else begin
          // open a hole at the sorted position and drop the block in
          f_shr       = 1'b1;
          f_set       = 1'b1;
          f_set_idx   = IW'(pos_idx);
          f_shift_idx = IW'(pos_idx);
          f_set_start = u_addr;
          f_set_len   = units;
          cnt_inc     = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------- free row
  logic [SW-1:0] fset_s;
  logic [LW-1:0] fset_l;

  assign fset_s = rebuild ? SW'(lo_units) : f_set_start;
  assign fset_l = rebuild ? usable_units : f_set_len;

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_free
    localparam logic [IW-1:0] IDX = IW'(i);
    localparam int NXT = (i + 1 == FREE_ENTRIES) ? 0 : i + 1;
    localparam int PRV = (i == 0) ? 0 : i - 1;
    cfla_free_op_t fop;
    always_comb begin
      fop.clr       = rebuild && (i != 0);
      fop.set       = (rebuild && (i == 0)) || (apply && f_set && (f_set_idx == IDX));
      fop.take_next = rot_free || (apply && f_shl && (IDX >= f_shift_idx));
      fop.take_prev = apply && f_shr && (IDX > f_shift_idx);
    end
    cfla_free_cell #(.SW(SW), .LW(LW)) u_cell (
      .clk        (clk),
      .op         (fop),
      .set_start  (fset_s),
      .set_len    (fset_l),
      .prev_start (fs[PRV]),
      .prev_len   (fl[PRV]),
      .next_start (fs[NXT]),
      .next_len   (fl[NXT]),
      .start      (fs[i]),
      .len        (fl[i])
    );
  end

  // ---------------------------------------------------------- live row
  for (genvar i = 0; i < LIVE_ENTRIES; i++) begin : g_live
    localparam logic [LIW-1:0] IDX = LIW'(i);
    localparam int NXT = (i + 1 == LIVE_ENTRIES) ? 0 : i + 1;
    cfla_live_op_t lop;
    always_comb begin
      lop.clr       = rebuild;
      lop.set       = apply && l_set && (slot == IDX);
      lop.take_next = rot_live;
    end
    cfla_live_cell #(.SW(SW), .LW(LW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (lop),
      .set_valid  (l_set_valid),
      .set_start  (best_start),
      .set_len    (units),
      .next_valid (lv[NXT]),
      .next_start (ls[NXT]),
      .next_len   (ll[NXT]),
      .valid      (lv[i]),
      .start      (ls[i]),
      .len        (ll[i])
    );
  end

  // ---------------------------------------------------------- sequencer
  logic [LW-1:0] diff;
  assign diff = fl[0] - units;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      done         <= 1'b0;
      t            <= '0;
      region_base  <= '0;
      region_bytes <= 19'(SPACE_BYTES);
      ff_thresh    <= 7'(THRESH_RESET);
      free_count   <= '0;
      bytes_free   <= '0;
      region_lo    <= '0;
      region_hi    <= '0;
      slot_found   <= 1'b0;
      hit          <= 1'b0;
      fit_found    <= 1'b0;
      fit_done     <= 1'b0;
      pos_found    <= 1'b0;
      have_prev    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_INIT: begin
          // one free extent spanning the usable region, no live blocks
          region_lo  <= lo_units;
          region_hi  <= lo_units + usable_units;
          free_count <= (usable != '0) ? CW'(1) : '0;
          bytes_free <= usable;
          state      <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            op_free    <= request.cmd;
            units      <= req_units;
            u_addr     <= SW'(request.free_addr >> ALIGN_SHIFT);
            first_fit  <= 32'(free_count) > 32'(ff_thresh);
            t          <= '0;
            slot_found <= 1'b0;
            hit        <= 1'b0;
            fit_found  <= 1'b0;
            fit_done   <= 1'b0;
            pos_found  <= 1'b0;
            have_prev  <= 1'b0;
            if ((request.cmd == CMD_ALLOC && alloc_bad) ||
                (request.cmd == CMD_FREE && free_bad)) begin
              // reject on the fields alone
              done                 <= 1'b1;
              response.result_addr <= '0;
              response.status      <= STAT_RANGE;
              response.free_bytes  <= bytes_free;
            end else begin
              state <= S_SCAN;
            end
          end else if (cfg_valid) begin
            unique case (cfg_index)
              REG_BASE: begin
                region_base <= cfg_data[17:0];
                state       <= S_INIT;
              end
              REG_BYTES: begin
                region_bytes <= cfg_data;
                state        <= S_INIT;
              end
              REG_THRESH: begin
                ff_thresh <= cfg_data[6:0];
                state     <= S_INIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // head cells show entry t of each row
          if (op_free == CMD_ALLOC) begin
            if (l_in && !slot_found && !lv[0]) begin
              slot_found <= 1'b1;
              slot       <= LIW'(t);
            end
            if (f_in && !fit_done && (fl[0] >= units)) begin
              if (first_fit || !fit_found || (diff < waste)) begin
                fit_found  <= 1'b1;
                best       <= IW'(t);
                best_start <= fs[0];
                best_len   <= fl[0];
                waste      <= diff;
                if (first_fit || (diff == '0)) begin
                  fit_done <= 1'b1;
                end
              end
            end
          end else begin
            if (l_in && !hit && lv[0] && (ls[0] == u_addr)) begin
              hit   <= 1'b1;
              slot  <= LIW'(t);
              units <= ll[0];
            end
            if (f_in && !pos_found) begin
              if (fs[0] > u_addr) begin
                pos_found  <= 1'b1;
                pos        <= CW'(t);
                next_start <= fs[0];
                next_len   <= fl[0];
              end else begin
                have_prev  <= 1'b1;
                prev_start <= fs[0];
                prev_len   <= fl[0];
              end
            end
          end
          if (t == TW'(MAXD - 1)) begin
            state <= S_APPLY;
          end else begin
            t <= t + 1'b1;
          end
        end
        S_APPLY: begin
          if (cnt_dec) begin
            free_count <= free_count - 1'b1;
          end else if (cnt_inc) begin
            free_count <= free_count + 1'b1;
          end
          bytes_free           <= bytes_next;
          done                 <= 1'b1;
          response.result_addr <= a_addr;
          response.status      <= a_status;
          response.free_bytes  <= bytes_next;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/cfla_checker.sv =====
// ---------------------------------------------------------------------------
// cfla_checker: port-level checks of the allocator
// Watches request, response and configuration beats over time.
// ---------------------------------------------------------------------------
`default_nettype none

module cfla_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input cfla_pkg::cfla_req_t request,
  input logic               done,
  input cfla_pkg::cfla_rsp_t response,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [1:0]         cfg_index
);

  import cfla_pkg::*;

  a_zero_size: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (request.cmd == CMD_ALLOC) && (request.alloc_bytes == '0)
    |=> done && (response.status == STAT_RANGE))
    else $error("zero-size allocate not rejected in the next cycle");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    done && (response.status != STAT_OK) |-> (response.result_addr == '0))
    else $error("failed request carries a nonzero address");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy && !start)
    else $error("register write offered while a request is active");

  a_rebuild: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready &&
    ((cfg_index == REG_BASE) || (cfg_index == REG_BYTES) || (cfg_index == REG_THRESH))
    |=> busy)
    else $error("register write did not start a table rebuild");

  a_bytes_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.free_bytes <= 19'(SPACE_BYTES)))
    else $error("free byte count beyond the address space");

endmodule

bind coalescing_free_list_allocator cfla_checker u_cfla_checker (.*);

`default_nettype wire
